FILE: hdl/slms_pkg.sv
//------------------------------------------------------------------------------
// slms_pkg
// Shared types, constants, microprogram and helper functions for the linear
// mask space block.
//------------------------------------------------------------------------------
package slms_pkg;

	localparam int WORD_BITS = 16;
	localparam int IDX_W     = $clog2(WORD_BITS);
	localparam int CNT_W     = $clog2(WORD_BITS + 1);
	localparam int ROT_W     = 4;
	localparam int VEC_W     = 16;
	localparam int RANK_W    = 5;
	localparam int STEP_W    = 3;

	// APB register map: register index sits at paddr[REG_IDX_W+1:2]
	localparam int REG_IDX_W = 2;
	localparam int ADDR_W    = REG_IDX_W + 2;
	localparam int DATA_W    = 32;

	localparam logic [REG_IDX_W-1:0] REG_ROT_AND        = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROT_AND_SECOND = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROT_XOR        = 2'd2;

	localparam logic [ROT_W-1:0] ROT_AND_RST        = 4'd1;
	localparam logic [ROT_W-1:0] ROT_AND_SECOND_RST = 4'd8;
	localparam logic [ROT_W-1:0] ROT_XOR_RST        = 4'd2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [STEP_W-1:0]    step_t;

	typedef struct packed {
		logic [ROT_W-1:0] rot_and;
		logic [ROT_W-1:0] rot_and_second;
		logic [ROT_W-1:0] rot_xor;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_FIX,
		OP_DECP,
		OP_ELIM,
		OP_EMIT_OFF,
		OP_EMIT_ROW
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_HIT,
		C_P_NZ,
		C_LAST_ROW,
		C_EMIT_DONE
	} cond_t;

	typedef struct packed {
		op_t   op;
		logic  wait_out;
		cond_t cond;
		step_t target;
	} ucode_t;

	// datapath -> sequencer
	typedef struct packed {
		logic in_valid;
		logic hit;
		logic p_nz;
		logic last_row;
		logic emit_done;
		logic out_busy;
	} status_t;

	// sequencer -> datapath
	typedef struct packed {
		op_t op;
	} ctrl_t;

	localparam step_t ST_WAIT = 3'd0;
	localparam step_t ST_SCAN = 3'd1;
	localparam step_t ST_DEC  = 3'd2;
	localparam step_t ST_OFF  = 3'd3;
	localparam step_t ST_CHK  = 3'd4;
	localparam step_t ST_ROW  = 3'd5;
	localparam step_t ST_ELIM = 3'd6;
	localparam step_t ST_NEXT = 3'd7;

	// microprogram: fall through to step+1 unless the condition holds
	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		w = '{op: OP_NOP, wait_out: 1'b0, cond: C_ALWAYS, target: ST_WAIT};
		case (s)
			ST_WAIT: w = '{op: OP_LOAD,     wait_out: 1'b0, cond: C_NO_IN,     target: ST_WAIT};
			ST_SCAN: w = '{op: OP_FIX,      wait_out: 1'b0, cond: C_HIT,       target: ST_ELIM};
			ST_DEC:  w = '{op: OP_DECP,     wait_out: 1'b0, cond: C_P_NZ,      target: ST_SCAN};
			ST_OFF:  w = '{op: OP_EMIT_OFF, wait_out: 1'b1, cond: C_NEVER,     target: ST_WAIT};
			ST_CHK:  w = '{op: OP_NOP,      wait_out: 1'b0, cond: C_EMIT_DONE, target: ST_WAIT};
			ST_ROW:  w = '{op: OP_EMIT_ROW, wait_out: 1'b1, cond: C_ALWAYS,    target: ST_CHK};
			ST_ELIM: w = '{op: OP_ELIM,     wait_out: 1'b0, cond: C_LAST_ROW,  target: ST_OFF};
			ST_NEXT: w = '{op: OP_NOP,      wait_out: 1'b0, cond: C_ALWAYS,    target: ST_SCAN};
			default: w = '{op: OP_NOP,      wait_out: 1'b0, cond: C_ALWAYS,    target: ST_WAIT};
		endcase
		return w;
	endfunction

	function automatic word_t rotr(word_t x, idx_t n);
		logic [2*WORD_BITS-1:0] t;
		t = {x, x} >> n;
		return t[WORD_BITS-1:0];
	endfunction

	// basis row i: bit beta[i+d] lands at i+d-a, bit beta[i] at i-d-a (mod word)
	function automatic word_t gen_row(word_t beta, idx_t i, idx_t d, idx_t a);
		idx_t  hi;
		idx_t  pa;
		idx_t  pb;
		word_t r;
		hi = IDX_W'(i + d);
		pa = IDX_W'(hi - a);
		pb = IDX_W'(i - d - a);
		r = '0;
		r[pa] = beta[hi];
		r[pb] = r[pb] ^ beta[i];
		return r;
	endfunction

endpackage

FILE: hdl/slms_mask_if.sv
//------------------------------------------------------------------------------
// slms_mask_if
// Input channel: one output mask per item.
//------------------------------------------------------------------------------
interface slms_mask_if import slms_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [VEC_W-1:0] out_mask;

	modport source (output valid, output out_mask, input ready);
	modport sink   (input valid, input out_mask, output ready);
endinterface

FILE: hdl/slms_space_if.sv
//------------------------------------------------------------------------------
// slms_space_if
// Output channel: offset item followed by basis row items.
//------------------------------------------------------------------------------
interface slms_space_if import slms_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VEC_W-1:0]  vector;
	logic              is_offset;
	logic [RANK_W-1:0] rank;
	logic              last;

	modport source (output valid, output vector, output is_offset, output rank,
		output last, input ready);
	modport sink   (input valid, input vector, input is_offset, input rank,
		input last, output ready);
endinterface

FILE: hdl/slms_cfg.sv
//------------------------------------------------------------------------------
// slms_cfg
// APB register file for the three rotation amounts.
//------------------------------------------------------------------------------
module slms_cfg import slms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_and        <= ROT_AND_RST;
			cfg_q.rot_and_second <= ROT_AND_SECOND_RST;
			cfg_q.rot_xor        <= ROT_XOR_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ROT_AND:        cfg_q.rot_and        <= pwdata[ROT_W-1:0];
				REG_ROT_AND_SECOND: cfg_q.rot_and_second <= pwdata[ROT_W-1:0];
				REG_ROT_XOR:        cfg_q.rot_xor        <= pwdata[ROT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_ROT_AND:        prdata = DATA_W'(cfg_q.rot_and);
			REG_ROT_AND_SECOND: prdata = DATA_W'(cfg_q.rot_and_second);
			REG_ROT_XOR:        prdata = DATA_W'(cfg_q.rot_xor);
			default:            prdata = '0;
		endcase
	end

endmodule

FILE: hdl/slms_seq.sv
//------------------------------------------------------------------------------
// slms_seq
// Microprogram sequencer: step counter, control ROM and conditional jumps.
//------------------------------------------------------------------------------
module slms_seq import slms_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl
);

	step_t  step_q;
	ucode_t uw;
	logic   hold;
	logic   take;

	assign uw   = ucode_rom(step_q);
	// emit steps stall while the output register is still full
	assign hold = uw.wait_out && status.out_busy;

	always_comb begin
		case (uw.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_IN:     take = !status.in_valid;
			C_HIT:       take = status.hit;
			C_P_NZ:      take = status.p_nz;
			C_LAST_ROW:  take = status.last_row;
			C_EMIT_DONE: take = status.emit_done;
			default:     take = 1'b0;
		endcase
	end

	assign ctrl.op = hold ? OP_NOP : uw.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else if (!hold) begin
			step_q <= take ? uw.target : STEP_W'(step_q + 1'b1);
		end
	end

endmodule

FILE: hdl/slms_dp.sv
//------------------------------------------------------------------------------
// slms_dp
// Elimination datapath: row bank, pivot row store, offset, counters and the
// output register.
//------------------------------------------------------------------------------
module slms_dp import slms_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  ctrl_t         ctrl,
	output status_t       status,
	slms_mask_if.sink     mask,
	slms_space_if.source  space
);

	// bank_q[0] is the row under elimination, later rows follow; zeros shift in
	word_t bank_q [WORD_BITS];
	word_t mem    [WORD_BITS];
	word_t off_q;
	idx_t  p_q;
	cnt_t  row_cnt_q;
	cnt_t  emit_idx_q;
	cnt_t  emit_prev;

	logic              out_valid_q;
	logic [VEC_W-1:0]  vector_q;
	logic              is_offset_q;
	logic [RANK_W-1:0] rank_q;
	logic              last_q;

	logic  load;
	logic  hit0;
	logic  hit_any;
	word_t first_row;
	word_t piv;
	idx_t  d_amt;
	idx_t  a_amt;
	word_t beta;

	assign mask.ready = (ctrl.op == OP_LOAD);
	assign load       = mask.valid && mask.ready;
	assign beta       = mask.out_mask;
	assign a_amt      = IDX_W'(cfg.rot_and);
	assign d_amt      = IDX_W'(cfg.rot_and_second - cfg.rot_and);
	assign emit_prev  = CNT_W'(emit_idx_q - 1'b1);

	// lowest later row holding the pivot bit
	always_comb begin
		hit_any   = 1'b0;
		first_row = '0;
		for (int j = WORD_BITS - 1; j >= 1; j--) begin
			if (bank_q[j][p_q]) begin
				hit_any   = 1'b1;
				first_row = bank_q[j];
			end
		end
	end

	assign hit0 = bank_q[0][p_q];
	assign piv  = bank_q[0];

	assign status.in_valid  = mask.valid;
	assign status.hit       = hit0 || hit_any;
	assign status.p_nz      = (p_q != '0);
	assign status.last_row  = (row_cnt_q == CNT_W'(WORD_BITS - 1));
	assign status.emit_done = (emit_idx_q == '0);
	assign status.out_busy  = out_valid_q && !space.ready;

	// row bank
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < WORD_BITS; i++)
				bank_q[i] <= gen_row(beta, IDX_W'(i), d_amt, a_amt);
		end else if (ctrl.op == OP_FIX) begin
			if (!hit0 && hit_any)
				bank_q[0] <= bank_q[0] ^ first_row;
		end else if (ctrl.op == OP_ELIM) begin
			for (int j = 1; j < WORD_BITS; j++)
				bank_q[j-1] <= bank_q[j] ^ (bank_q[j][p_q] ? piv : '0);
			bank_q[WORD_BITS-1] <= '0;
		end
	end

	// pivot row store and output payload
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_ELIM)
			mem[row_cnt_q[IDX_W-1:0]] <= piv;
		if (ctrl.op == OP_EMIT_OFF) begin
			vector_q    <= VEC_W'(off_q);
			is_offset_q <= 1'b1;
			rank_q      <= RANK_W'(row_cnt_q);
			last_q      <= (row_cnt_q == '0);
		end else if (ctrl.op == OP_EMIT_ROW) begin
			vector_q    <= VEC_W'(mem[emit_prev[IDX_W-1:0]]);
			is_offset_q <= 1'b0;
			last_q      <= (emit_idx_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= '0;
			p_q         <= '0;
			row_cnt_q   <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				off_q     <= rotr(beta, IDX_W'(cfg.rot_xor));
				p_q       <= IDX_W'(WORD_BITS - 1);
				row_cnt_q <= '0;
			end
			if (ctrl.op == OP_DECP && p_q != '0)
				p_q <= IDX_W'(p_q - 1'b1);
			if (ctrl.op == OP_ELIM) begin
				if (off_q[p_q])
					off_q <= off_q ^ piv;
				row_cnt_q <= CNT_W'(row_cnt_q + 1'b1);
			end
			if (ctrl.op == OP_EMIT_OFF)
				emit_idx_q <= row_cnt_q;
			else if (ctrl.op == OP_EMIT_ROW)
				emit_idx_q <= emit_prev;
			if (ctrl.op == OP_EMIT_OFF || ctrl.op == OP_EMIT_ROW)
				out_valid_q <= 1'b1;
			else if (space.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign space.valid     = out_valid_q;
	assign space.vector    = vector_q;
	assign space.is_offset = is_offset_q;
	assign space.rank      = rank_q;
	assign space.last      = last_q;

endmodule

FILE: hdl/simon_linear_mask_space.sv
//------------------------------------------------------------------------------
// simon_linear_mask_space
// Affine space of input masks for one output mask of a Simon-like round,
// reduced by GF(2) elimination under a microcoded sequencer.
//
//   channel  dir  handshake            payload
//   mask     in   valid/ready          out_mask[15:0]
//   space    out  valid/ready          vector[15:0] is_offset rank[4:0] last
//   apb      in   psel/penable, pready rot_and rot_and_second rot_xor at 0/4/8
//
// For one mask item, where r is the rank: one load step, a scan and a decrement
// per pivot position that misses (every position misses once below full rank),
// scan, eliminate and advance per pivot row, then 2 + 2*r emit steps.
// Results: offset item first, then r basis rows from the highest row down.
// A full output register stalls the emit steps; the next mask is taken once
// the last item has been loaded into the output register.
// Reset clears control state and restores rotation amounts 1, 8, 2.
//------------------------------------------------------------------------------
module simon_linear_mask_space import slms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	slms_mask_if.sink         mask,
	slms_space_if.source      space,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t    cfg;
	ctrl_t   ctrl;
	status_t status;

	slms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slms_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	slms_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ctrl   (ctrl),
		.status (status),
		.mask   (mask),
		.space  (space)
	);

endmodule
